// ===== src/playout_stall_tracker_macros.svh =====
// Assertion macros for the playout stall tracker.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef PLAYOUT_STALL_TRACKER_MACROS_SVH
`define PLAYOUT_STALL_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define PST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/pst_pkg.sv =====
// Types and constants shared by the playout stall tracker modules.
// No dependencies.
package pst_pkg;

    localparam int TS_W     = 32;
    localparam int TIME_W   = 48;
    localparam int CNT_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [9:0]        US_PER_MS        = 10'd1000;
    localparam logic [TIME_W-1:0] ENC_DELAY_US     = 48'd10000;
    localparam logic [CNT_W-1:0]  MIN_PREBUF_RESET = 16'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PREBUF = 2'd0,
        CFG_START_TIME = 2'd1,
        CFG_REQ_TIME   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic            en;
        logic            sel;
        logic [TS_W-1:0] ts;
    } t_ts_upd;

    typedef struct packed {
        logic              ts_update;
        logic              stream_sel;
        logic [TS_W-1:0]   stream_ts_ms;
        logic [TIME_W-1:0] now_us;
        logic              download_done;
        logic              transfer_complete;
    } t_event;

    typedef struct packed {
        logic              playing;
        logic [TS_W-1:0]   playout_ts_ms;
        logic [TS_W-1:0]   playable_ts_ms;
        logic              stall_started;
        logic              playout_resumed;
        logic [TIME_W-1:0] wait_us;
        logic [CNT_W-1:0]  stall_count;
        logic [TIME_W-1:0] total_stall_us;
        logic [TIME_W-1:0] last_stall_us;
        logic [TIME_W-1:0] initial_prebuf_us;
        logic [TIME_W-1:0] startup_us;
    } t_result;

endpackage

// ===== src/pst_ts_min.sv =====
// Per-stream timestamp store and minimum search for the stall tracker.
// Depends on pst_pkg.
module pst_ts_min #(
    parameter int NUM_STREAMS = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pst_pkg::t_ts_upd      i_upd,
    output logic [pst_pkg::TS_W-1:0] o_min
);
    import pst_pkg::*;

    logic [TS_W-1:0] r_ts [NUM_STREAMS];
    logic [TS_W-1:0] n_ts [NUM_STREAMS];

    always_comb begin
        logic [TS_W-1:0] v_min;
        for (int i = 0; i < NUM_STREAMS; i++) begin
            n_ts[i] = (i_upd.en && (int'(i_upd.sel) == i)) ? i_upd.ts : r_ts[i];
        end
        v_min = n_ts[0];
        for (int i = 1; i < NUM_STREAMS; i++) begin
            if (n_ts[i] < v_min) begin
                v_min = n_ts[i];
            end
        end
        o_min = v_min;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_STREAMS; i++) begin
            if (!i_rst_n) begin
                r_ts[i] <= '0;
            end else begin
                r_ts[i] <= n_ts[i];
            end
        end
    end

endmodule

// ===== src/playout_stall_tracker.sv =====
// Playout stall tracker top level: input register, stall/playout state and result register.
// Depends on pst_pkg, pst_ts_min and playout_stall_tracker_macros.svh.
//
//   channel   direction  handshake                 payload
//   event     in         i_in_valid / o_in_ready   ts update, stream, time, flags
//   result    out        o_out_valid / i_out_ready playout state and stall statistics
//   config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// An event is taken into the input register when it is accepted, and its result is loaded
// into the result register once that register is free or being read, so a stalled result
// delays it. One event is accepted per cycle while the result side does not stall; the path
// through the buffered-time multiply, deadline add and compare sets the clock. Reset is
// synchronous and returns all statistics to zero. A stalled result holds both registers and
// deasserts o_in_ready only when both are full.
`include "playout_stall_tracker_macros.svh"

module playout_stall_tracker #(
    parameter int NUM_STREAMS = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_ts_update,
    input  logic                              i_stream_sel,
    input  logic [pst_pkg::TS_W-1:0]          i_stream_ts_ms,
    input  logic [pst_pkg::TIME_W-1:0]        i_now_us,
    input  logic                              i_download_done,
    input  logic                              i_transfer_complete,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_playing,
    output logic [pst_pkg::TS_W-1:0]          o_playout_ts_ms,
    output logic [pst_pkg::TS_W-1:0]          o_playable_ts_ms,
    output logic                              o_stall_started,
    output logic                              o_playout_resumed,
    output logic [pst_pkg::TIME_W-1:0]        o_wait_us,
    output logic [pst_pkg::CNT_W-1:0]         o_stall_count,
    output logic [pst_pkg::TIME_W-1:0]        o_total_stall_us,
    output logic [pst_pkg::TIME_W-1:0]        o_last_stall_us,
    output logic [pst_pkg::TIME_W-1:0]        o_initial_prebuf_us,
    output logic [pst_pkg::TIME_W-1:0]        o_startup_us,
    input  logic                              i_cfg_we,
    input  logic [pst_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pst_pkg::TIME_W-1:0]        i_cfg_data
);
    import pst_pkg::*;

    localparam int DL_W = TIME_W + 1;

    logic              r_in_valid;
    t_event            r_in;
    logic              r_out_valid;
    t_result           r_out;

    logic [CNT_W-1:0]  r_min_prebuf;
    logic [TIME_W-1:0] r_start_time;
    logic [TIME_W-1:0] r_req_time;

    logic              r_first_seen;
    logic [TS_W-1:0]   r_seg_start;
    logic              r_play;
    logic [TIME_W-1:0] r_play_start;
    logic [TIME_W-1:0] r_empty_since;
    logic              r_init_done;
    logic [CNT_W-1:0]  r_cur_min;
    logic [CNT_W-1:0]  r_stalls;
    logic [TIME_W-1:0] r_total;
    logic [TIME_W-1:0] r_last;
    logic [TIME_W-1:0] r_prebuf;
    logic [TIME_W-1:0] r_startup;

    logic              w_adv;
    logic              w_step;
    t_ts_upd           w_upd;
    logic [TS_W-1:0]   w_tsnow;

    logic [TS_W-1:0]   w_seg0;
    logic [TIME_W-1:0] w_empty0;
    logic [TS_W-1:0]   w_buf_ms;
    logic [41:0]       w_buf_us;
    logic [DL_W-1:0]   w_deadline;
    logic [DL_W-1:0]   w_slack;
    logic [DL_W-1:0]   w_wait_raw;
    logic              w_stall;
    logic              w_play1;
    logic [TS_W-1:0]   w_seg1;
    logic [TIME_W-1:0] w_empty1;
    logic [TS_W-1:0]   w_buf1;
    logic              w_resume;
    logic [TIME_W-1:0] w_wait;
    logic [TIME_W-1:0] w_dur;
    logic [DL_W-1:0]   w_total_sum;
    logic [TIME_W-1:0] w_prebuf_d;
    logic [TIME_W-1:0] w_startup_d;

    logic [TIME_W-1:0] n_total;
    logic [CNT_W-1:0]  n_stalls;
    logic [TIME_W-1:0] n_last;
    logic [TIME_W-1:0] n_prebuf;
    logic [TIME_W-1:0] n_startup;
    logic              n_init_done;
    logic [CNT_W-1:0]  n_cur_min;
    t_result           n_out;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_step     = r_in_valid && w_adv;

    assign w_upd.en  = w_step && r_in.ts_update;
    assign w_upd.sel = r_in.stream_sel;
    assign w_upd.ts  = r_in.stream_ts_ms;

    pst_ts_min #(
        .NUM_STREAMS(NUM_STREAMS)
    ) u_ts_min (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_upd  (w_upd),
        .o_min  (w_tsnow)
    );

    always_comb begin
        w_seg0     = r_first_seen ? r_seg_start : w_tsnow;
        w_empty0   = r_first_seen ? r_empty_since : r_in.now_us;
        w_buf_ms   = (w_tsnow >= w_seg0) ? (w_tsnow - w_seg0) : '0;
        w_buf_us   = 42'(w_buf_ms) * 42'(US_PER_MS);
        w_deadline = {1'b0, r_play_start} + DL_W'(w_buf_us);
        w_stall    = r_play && (w_deadline < {1'b0, r_in.now_us});
        w_slack    = w_deadline - {1'b0, r_in.now_us};
        w_wait_raw = w_slack - {1'b0, ENC_DELAY_US};
        w_wait     = '0;
        if (r_play && !w_stall && !r_in.transfer_complete
                && (w_slack > {1'b0, ENC_DELAY_US})) begin
            w_wait = w_wait_raw[TIME_W] ? '1 : w_wait_raw[TIME_W-1:0];
        end

        w_play1  = r_play && !w_stall;
        w_seg1   = w_stall ? w_tsnow : w_seg0;
        w_empty1 = w_stall ? w_deadline[TIME_W-1:0] : w_empty0;
        w_buf1   = w_stall ? '0 : w_buf_ms;
        w_resume = !w_play1 && ((w_buf1 >= {16'd0, r_cur_min}) || r_in.download_done);

        w_dur       = (r_in.now_us >= w_empty1) ? (r_in.now_us - w_empty1) : '0;
        w_total_sum = {1'b0, r_total} + {1'b0, w_dur};
        w_prebuf_d  = (r_in.now_us >= r_start_time) ? (r_in.now_us - r_start_time) : '0;
        w_startup_d = (r_in.now_us >= r_req_time) ? (r_in.now_us - r_req_time) : '0;

        n_total     = r_total;
        n_stalls    = r_stalls;
        n_last      = r_last;
        n_prebuf    = r_prebuf;
        n_startup   = r_startup;
        n_init_done = r_init_done;
        n_cur_min   = r_cur_min;
        if (w_resume) begin
            if (!r_init_done) begin
                n_init_done = 1'b1;
                n_prebuf    = w_prebuf_d;
                n_startup   = w_startup_d;
                n_cur_min   = r_min_prebuf >> 1;
            end else begin
                n_stalls = (r_stalls != '1) ? (r_stalls + 16'd1) : r_stalls;
                n_last   = w_dur;
                n_total  = w_total_sum[TIME_W] ? '1 : w_total_sum[TIME_W-1:0];
            end
        end

        n_out.playing           = w_play1 || w_resume;
        n_out.playout_ts_ms     = w_play1 ? w_tsnow : w_seg1;
        n_out.playable_ts_ms    = w_tsnow;
        n_out.stall_started     = w_stall;
        n_out.playout_resumed   = w_resume;
        n_out.wait_us           = w_wait;
        n_out.stall_count       = n_stalls;
        n_out.total_stall_us    = n_total;
        n_out.last_stall_us     = n_last;
        n_out.initial_prebuf_us = n_prebuf;
        n_out.startup_us        = n_startup;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_min_prebuf  <= MIN_PREBUF_RESET;
            r_start_time  <= '0;
            r_req_time    <= '0;
            r_first_seen  <= 1'b0;
            r_seg_start   <= '0;
            r_play        <= 1'b0;
            r_play_start  <= '0;
            r_empty_since <= '0;
            r_init_done   <= 1'b0;
            r_cur_min     <= MIN_PREBUF_RESET;
            r_stalls      <= '0;
            r_total       <= '0;
            r_last        <= '0;
            r_prebuf      <= '0;
            r_startup     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_step) begin
                r_first_seen  <= 1'b1;
                r_seg_start   <= w_seg1;
                r_play        <= w_play1 || w_resume;
                r_play_start  <= w_resume ? r_in.now_us : r_play_start;
                r_empty_since <= w_empty1;
                r_init_done   <= n_init_done;
                r_cur_min     <= n_cur_min;
                r_stalls      <= n_stalls;
                r_total       <= n_total;
                r_last        <= n_last;
                r_prebuf      <= n_prebuf;
                r_startup     <= n_startup;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_PREBUF: begin
                        r_min_prebuf <= i_cfg_data[CNT_W-1:0];
                        r_cur_min    <= r_init_done ? (i_cfg_data[CNT_W-1:0] >> 1)
                                                    : i_cfg_data[CNT_W-1:0];
                    end
                    CFG_START_TIME: begin
                        r_start_time <= i_cfg_data;
                    end
                    CFG_REQ_TIME: begin
                        r_req_time <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.ts_update         <= i_ts_update;
            r_in.stream_sel        <= i_stream_sel;
            r_in.stream_ts_ms      <= i_stream_ts_ms;
            r_in.now_us            <= i_now_us;
            r_in.download_done     <= i_download_done;
            r_in.transfer_complete <= i_transfer_complete;
        end
        if (w_step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_playing           = r_out.playing;
    assign o_playout_ts_ms     = r_out.playout_ts_ms;
    assign o_playable_ts_ms    = r_out.playable_ts_ms;
    assign o_stall_started     = r_out.stall_started;
    assign o_playout_resumed   = r_out.playout_resumed;
    assign o_wait_us           = r_out.wait_us;
    assign o_stall_count       = r_out.stall_count;
    assign o_total_stall_us    = r_out.total_stall_us;
    assign o_last_stall_us     = r_out.last_stall_us;
    assign o_initial_prebuf_us = r_out.initial_prebuf_us;
    assign o_startup_us        = r_out.startup_us;

    `PST_ASSERT_IMP(a_resume_plays, i_clk, i_rst_n,
        r_out_valid && r_out.playout_resumed, r_out.playing)
    `PST_ASSERT_IMP(a_stall_stops, i_clk, i_rst_n,
        r_out_valid && r_out.stall_started && !r_out.playout_resumed, !r_out.playing)
    `PST_ASSERT_IMP(a_wait_only_playing, i_clk, i_rst_n,
        r_out_valid && (r_out.wait_us != '0),
        r_out.playing && !r_out.stall_started && !r_out.playout_resumed)
    `PST_ASSERT_NXT(a_stalls_monotonic, i_clk, i_rst_n, 1'b1, r_stalls >= $past(r_stalls))

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for playout_stall_tracker: directed table, then random event phases.
// Depends on pst_pkg and the playout_stall_tracker RTL only.
module tb_top;
    import pst_pkg::*;

    localparam logic [TIME_W-1:0]    TIME_MAX         = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE    = 2'd3;
    localparam int                   N_DIRECTED       = 23;
    localparam int                   N_PHASES         = 4;
    localparam int                   ITEMS_PER_PHASE  = 350;
    localparam int                   HOLD_OFF_CYCLES  = 400;
    localparam int                   CYCLE_LIMIT      = 200000;

    typedef struct packed {
        t_event  ev;
        logic    typed;
        t_result res;
    } t_dir_row;

    localparam t_result AT_RESET   = '0;
    localparam t_result FIRST_FILL = '{playable_ts_ms: 32'd1500, default: '0};
    localparam t_result FIRST_PLAY = '{playing: 1'b1, playable_ts_ms: 32'd2500,
                                       playout_resumed: 1'b1, startup_us: 48'd7000,
                                       default: '0};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_ts_update = 1'b0;
    logic                 i_stream_sel = 1'b0;
    logic [TS_W-1:0]      i_stream_ts_ms = '0;
    logic [TIME_W-1:0]    i_now_us = '0;
    logic                 i_download_done = 1'b0;
    logic                 i_transfer_complete = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_playing;
    logic [TS_W-1:0]      o_playout_ts_ms;
    logic [TS_W-1:0]      o_playable_ts_ms;
    logic                 o_stall_started;
    logic                 o_playout_resumed;
    logic [TIME_W-1:0]    o_wait_us;
    logic [CNT_W-1:0]     o_stall_count;
    logic [TIME_W-1:0]    o_total_stall_us;
    logic [TIME_W-1:0]    o_last_stall_us;
    logic [TIME_W-1:0]    o_initial_prebuf_us;
    logic [TIME_W-1:0]    o_startup_us;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [TIME_W-1:0]    i_cfg_data = '0;

    t_result pending_results[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    bit      hold_off_req = 1'b0;

    logic [TS_W-1:0]   trk_stream_ts [2] = '{'0, '0};
    bit                trk_event_seen = 1'b0;
    logic [TS_W-1:0]   trk_segment_ts = '0;
    bit                trk_playing = 1'b0;
    logic [TIME_W-1:0] trk_play_start = '0;
    logic [TIME_W-1:0] trk_empty_since = '0;
    bit                trk_first_start_done = 1'b0;
    logic [CNT_W-1:0]  trk_threshold_ms = MIN_PREBUF_RESET;
    logic [CNT_W-1:0]  trk_stalls = '0;
    logic [TIME_W-1:0] trk_stall_sum = '0;
    logic [TIME_W-1:0] trk_last_stall = '0;
    logic [TIME_W-1:0] trk_prebuf = '0;
    logic [TIME_W-1:0] trk_startup = '0;
    logic [CNT_W-1:0]  cfg_min_prebuf = MIN_PREBUF_RESET;
    logic [TIME_W-1:0] cfg_start_time = '0;
    logic [TIME_W-1:0] cfg_request_time = '0;

    logic [TIME_W-1:0] wall_us = 48'd1000000;
    logic [TS_W-1:0]   media_ms [2] = '{32'd0, 32'd0};
    int                wall_step_max = 200000;
    int                media_step_max = 300;
    int                burst_left = 0;

    playout_stall_tracker dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_ts_update         (i_ts_update),
        .i_stream_sel        (i_stream_sel),
        .i_stream_ts_ms      (i_stream_ts_ms),
        .i_now_us            (i_now_us),
        .i_download_done     (i_download_done),
        .i_transfer_complete (i_transfer_complete),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_playing           (o_playing),
        .o_playout_ts_ms     (o_playout_ts_ms),
        .o_playable_ts_ms    (o_playable_ts_ms),
        .o_stall_started     (o_stall_started),
        .o_playout_resumed   (o_playout_resumed),
        .o_wait_us           (o_wait_us),
        .o_stall_count       (o_stall_count),
        .o_total_stall_us    (o_total_stall_us),
        .o_last_stall_us     (o_last_stall_us),
        .o_initial_prebuf_us (o_initial_prebuf_us),
        .o_startup_us        (o_startup_us),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_event ev_of(logic upd, logic sel, logic [TS_W-1:0] ts,
                                     logic [TIME_W-1:0] now, logic done, logic cpl);
        t_event ev;
        ev.ts_update         = upd;
        ev.stream_sel        = sel;
        ev.stream_ts_ms      = ts;
        ev.now_us            = now;
        ev.download_done     = done;
        ev.transfer_complete = cpl;
        return ev;
    endfunction

    function automatic logic [TIME_W-1:0] clip48(logic [63:0] v);
        return (v > {16'd0, TIME_MAX}) ? TIME_MAX : v[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] floor_sub(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        return (a >= b) ? a - b : '0;
    endfunction

    function automatic logic [63:0] buffered_ms(logic [TS_W-1:0] playable);
        return (playable >= trk_segment_ts) ? {32'd0, playable - trk_segment_ts} : 64'd0;
    endfunction

    task automatic advance_tracker(input t_event ev, output t_result res);
        logic [TS_W-1:0]   playable;
        logic [63:0]       deadline;
        logic [63:0]       now64;
        logic [TIME_W-1:0] stall_us;
        res = '0;
        now64 = {16'd0, ev.now_us};
        if (ev.ts_update) begin
            trk_stream_ts[ev.stream_sel] = ev.stream_ts_ms;
        end
        playable = (trk_stream_ts[1] < trk_stream_ts[0]) ? trk_stream_ts[1] : trk_stream_ts[0];
        if (!trk_event_seen) begin
            trk_event_seen  = 1'b1;
            trk_empty_since = ev.now_us;
            trk_segment_ts  = playable;
        end
        if (trk_playing) begin
            deadline = {16'd0, trk_play_start} + buffered_ms(playable) * US_PER_MS;
            if (deadline < now64) begin
                trk_empty_since   = clip48(deadline);
                trk_playing       = 1'b0;
                trk_segment_ts    = playable;
                res.stall_started = 1'b1;
            end else if (!ev.transfer_complete && deadline - now64 > {16'd0, ENC_DELAY_US}) begin
                res.wait_us = clip48(deadline - now64 - {16'd0, ENC_DELAY_US});
            end
            res.playout_ts_ms = playable;
        end
        if (!trk_playing) begin
            if (buffered_ms(playable) >= {48'd0, trk_threshold_ms} || ev.download_done) begin
                trk_playing         = 1'b1;
                trk_play_start      = ev.now_us;
                res.playout_resumed = 1'b1;
                if (!trk_first_start_done) begin
                    trk_first_start_done = 1'b1;
                    trk_prebuf           = floor_sub(ev.now_us, cfg_start_time);
                    trk_startup          = floor_sub(ev.now_us, cfg_request_time);
                    trk_threshold_ms     = cfg_min_prebuf >> 1;
                end else begin
                    stall_us = floor_sub(ev.now_us, trk_empty_since);
                    if (trk_stalls != '1) begin
                        trk_stalls++;
                    end
                    trk_last_stall = stall_us;
                    trk_stall_sum  = clip48({16'd0, trk_stall_sum} + {16'd0, stall_us});
                end
            end
            res.playout_ts_ms = trk_segment_ts;
        end
        res.playing           = trk_playing;
        res.playable_ts_ms    = playable;
        res.stall_count       = trk_stalls;
        res.total_stall_us    = trk_stall_sum;
        res.last_stall_us     = trk_last_stall;
        res.initial_prebuf_us = trk_prebuf;
        res.startup_us        = trk_startup;
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_MIN_PREBUF: begin
                cfg_min_prebuf   = data[CNT_W-1:0];
                trk_threshold_ms = trk_first_start_done ? cfg_min_prebuf >> 1 : cfg_min_prebuf;
            end
            CFG_START_TIME: cfg_start_time = data;
            CFG_REQ_TIME:   cfg_request_time = data;
            default: ;
        endcase
    endtask

    task automatic offer_event(input t_event ev, input logic typed, input t_result typed_res);
        t_result predicted;
        i_in_valid          <= 1'b1;
        i_ts_update         <= ev.ts_update;
        i_stream_sel        <= ev.stream_sel;
        i_stream_ts_ms      <= ev.stream_ts_ms;
        i_now_us            <= ev.now_us;
        i_download_done     <= ev.download_done;
        i_transfer_complete <= ev.transfer_complete;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        advance_tracker(ev, predicted);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end else begin
            burst_left--;
        end
    endtask

    task automatic make_event(output t_event ev);
        logic sel;
        if ($urandom_range(0, 99) < 6) begin
            ev = ev_of(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                       {16'($urandom_range(0, 65535)), 32'($urandom)},
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
            sel = 1'($urandom_range(0, 1));
            wall_us += 48'($urandom_range(0, wall_step_max));
            ev = ev_of($urandom_range(0, 9) < 7, sel, $urandom, wall_us,
                       $urandom_range(0, 99) < 3, $urandom_range(0, 9) == 0);
            if (ev.ts_update) begin
                media_ms[sel] += 32'($urandom_range(0, media_step_max));
                ev.stream_ts_ms = media_ms[sel];
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: result with no event pending, playable %0h", $time, o_playable_ts_ms);
            mismatch_count++;
        end else begin
            want = pending_results.pop_front();
            compare_field("playing", 64'(want.playing), 64'(o_playing));
            compare_field("playout_ts_ms", 64'(want.playout_ts_ms), 64'(o_playout_ts_ms));
            compare_field("playable_ts_ms", 64'(want.playable_ts_ms), 64'(o_playable_ts_ms));
            compare_field("stall_started", 64'(want.stall_started), 64'(o_stall_started));
            compare_field("playout_resumed", 64'(want.playout_resumed),
                          64'(o_playout_resumed));
            compare_field("wait_us", 64'(want.wait_us), 64'(o_wait_us));
            compare_field("stall_count", 64'(want.stall_count), 64'(o_stall_count));
            compare_field("total_stall_us", 64'(want.total_stall_us), 64'(o_total_stall_us));
            compare_field("last_stall_us", 64'(want.last_stall_us), 64'(o_last_stall_us));
            compare_field("initial_prebuf_us", 64'(want.initial_prebuf_us),
                          64'(o_initial_prebuf_us));
            compare_field("startup_us", 64'(want.startup_us), 64'(o_startup_us));
        end
    endtask

    // The result side alternates between no stalls, light stalls and heavy stalls, and holds
    // off completely for a long stretch when asked, so the block backs up into its input.
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                check_result();
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 150);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    default: i_out_ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    initial begin
        t_dir_row directed_rows [N_DIRECTED];
        t_event   ev;
        logic [CNT_W-1:0] min_setting;
        logic [TIME_W-1:0] start_setting;
        logic [TIME_W-1:0] request_setting;

        directed_rows = '{
            '{ev_of(0, 1, 32'hFFFF_FFFF, 48'd5000, 0, 0), 1'b1, AT_RESET},
            '{ev_of(1, 0, 32'd1500, 48'd6000, 0, 0), 1'b1, AT_RESET},
            '{ev_of(1, 1, 32'd3000, 48'd7000, 0, 0), 1'b1, FIRST_FILL},
            '{ev_of(1, 0, 32'd2500, 48'd8000, 0, 0), 1'b1, FIRST_PLAY},
            '{ev_of(0, 0, 32'd0, 48'd9000, 0, 0), 1'b0, AT_RESET},
            '{ev_of(0, 1, 32'd0, 48'd9500, 0, 1), 1'b0, AT_RESET},
            '{ev_of(0, 0, 32'd0, 48'd3000000, 0, 0), 1'b0, AT_RESET},
            '{ev_of(1, 0, 32'd3000, 48'd3100000, 0, 0), 1'b0, AT_RESET},
            '{ev_of(1, 1, 32'd100, 48'd3200000, 0, 0), 1'b0, AT_RESET},
            '{ev_of(1, 1, 32'd4000, 48'd2000000, 1, 0), 1'b0, AT_RESET},
            '{ev_of(1, 0, 32'hFFFF_FFFF, 48'd2100000, 0, 0), 1'b0, AT_RESET},
            '{ev_of(1, 1, 32'hFFFF_FFFF, 48'd2200000, 0, 0), 1'b0, AT_RESET},
            '{ev_of(0, 0, 32'd0, 48'hFFFF_FFFF_FFF0, 1, 0), 1'b0, AT_RESET},
            '{ev_of(1, 0, 32'd0, 48'd0, 0, 0), 1'b0, AT_RESET},
            '{ev_of(0, 1, 32'd0, TIME_MAX, 0, 0), 1'b0, AT_RESET},
            '{ev_of(1, 0, 32'd5000, 48'd50000, 0, 0), 1'b0, AT_RESET},
            '{ev_of(1, 0, 32'd0, TIME_MAX - 48'd100, 1, 0), 1'b0, AT_RESET},
            '{ev_of(1, 0, 32'hFFFF_FFFF, 48'd0, 0, 0), 1'b0, AT_RESET},
            '{ev_of(1, 1, 32'd0, TIME_MAX, 0, 0), 1'b0, AT_RESET},
            '{ev_of(1, 1, 32'd20, 48'd60000, 1, 0), 1'b0, AT_RESET},
            '{ev_of(0, 1, 32'hFFFF_FFFF, 48'd70000, 0, 0), 1'b0, AT_RESET},
            '{ev_of(0, 0, 32'd0, TIME_MAX - 48'd200, 1, 0), 1'b0, AT_RESET},
            '{ev_of(1, 0, 32'd0, TIME_MAX, 0, 0), 1'b0, AT_RESET}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_setting(CFG_START_TIME, TIME_MAX);
        write_setting(CFG_REQ_TIME, 48'd1000);
        write_setting(CFG_IDX_SPARE, {16'($urandom_range(0, 65535)), 32'($urandom)});
        i_cfg_we <= 1'b0;

        foreach (directed_rows[i]) begin
            offer_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].res);
            pace_sender();
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            i_in_valid <= 1'b0;
            while (pending_results.size() != 0) begin
                @(posedge i_clk);
            end
            case (phase)
                0: begin
                    min_setting     = '0;
                    start_setting   = '0;
                    request_setting = TIME_MAX;
                    wall_step_max   = 200000;
                    media_step_max  = 300;
                end
                1: begin
                    min_setting     = '1;
                    start_setting   = {16'($urandom_range(0, 65535)), 32'($urandom)};
                    request_setting = '0;
                    wall_step_max   = 600000;
                    media_step_max  = 2500;
                end
                2: begin
                    min_setting     = 16'($urandom_range(1, 6000));
                    start_setting   = TIME_MAX;
                    request_setting = {16'($urandom_range(0, 65535)), 32'($urandom)};
                    wall_step_max   = 300000;
                    media_step_max  = 600;
                end
                default: begin
                    min_setting     = MIN_PREBUF_RESET;
                    start_setting   = {16'($urandom_range(0, 65535)), 32'($urandom)};
                    request_setting = {16'($urandom_range(0, 65535)), 32'($urandom)};
                    wall_step_max   = 150000;
                    media_step_max  = 250;
                end
            endcase
            write_setting(CFG_MIN_PREBUF, {32'd0, min_setting});
            write_setting(CFG_START_TIME, start_setting);
            write_setting(CFG_REQ_TIME, request_setting);
            i_cfg_we <= 1'b0;
            if (phase == 2) begin
                hold_off_req = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                make_event(ev);
                offer_event(ev, 1'b0, AT_RESET);
                pace_sender();
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/pst_pkg.sv
src/pst_ts_min.sv
src/playout_stall_tracker.sv
test/tb_top.sv
